// ===== sv/cphss_pkg.sv =====
// ----------------------------------------------------------------------------
// cphss_pkg
// Types and constants shared by the call profiler and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none
package cphss_pkg;

  localparam int TABLE_SLOTS  = 1024;
  localparam int STACK_LEVELS = 256;
  localparam int THREAD_SLOTS = 8;

  localparam int ENT_W  = $clog2(TABLE_SLOTS);
  localparam int LVL_W  = $clog2(STACK_LEVELS);
  localparam int THR_W  = $clog2(THREAD_SLOTS);
  localparam int DEPTH_W = LVL_W + 1;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 336;

  typedef enum logic [1:0] {
    REQ_ENTER = 2'd0,
    REQ_EXIT  = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FUNC_FULL   = 3'd1,
    ST_THREAD_FULL = 3'd2,
    ST_OVERFLOW    = 3'd3,
    ST_UNDERFLOW   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PROBE,
    S_PROBE_CHK,
    S_EXIT_STK,
    S_CALLER,
    S_C_MOD,
    S_E_RD,
    S_E_MOD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] addr;
    logic [31:0] enter_cnt;
    logic [31:0] exit_cnt;
    logic [31:0] away_cnt;
    logic [31:0] back_cnt;
    logic [63:0] total_time;
    logic [63:0] outside_time;
  } entry_t;

  typedef struct packed {
    logic [ENT_W-1:0] slot;
    logic [31:0]      ret;
  } frame_t;

endpackage
`default_nettype wire

// ===== sv/call_profiler_hash_shadow_stack_top.sv =====
// ----------------------------------------------------------------------------
// call_profiler_hash_shadow_stack_top
// Call profiler: thread tag table in registers, hashed function statistic table
// and per-thread shadow stacks in synchronous memories.
// ----------------------------------------------------------------------------
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tuser req_type, tdata event fields
// out_    | out | out_tvalid/tready  | tuser status, tdata entry fields
//
// After reset a clearing pass zeroes all 1024 statistic entries; no request is
// taken until it ends. Read: decode, entry read, result. Exit: decode, stack pop,
// caller read and write when a caller is charged, entry read and write, result.
// Enter: decode, one probe step per table slot tried (one entry-memory read per
// step), stack push, caller read and write when charged, entry read and write,
// result. Thread full, underflow: decode, result. One request at a time; a result
// waits in the output register while the next request is taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none
module call_profiler_hash_shadow_stack_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: thread_tag[31:0], func_addr[63:32], return_addr[95:64],
  //        timestamp[159:96], entry_index[169:160], zero pad
  input  wire logic [175:0] in_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: slot_index[9:0], entry_addr[41:10], enter_count[73:42],
  //        exit_count[105:74], away_count[137:106], back_count[169:138],
  //        total_time_acc[233:170], outside_time_acc[297:234],
  //        popped_return[329:298], zero pad
  output logic [335:0]      out_tdata,
  // tuser: status[2:0]
  output logic [2:0]        out_tuser
);

  localparam int ENT_W = cphss_pkg::ENT_W;
  localparam int THR_W = cphss_pkg::THR_W;
  localparam int LVL_W = cphss_pkg::LVL_W;
  localparam int DW    = cphss_pkg::DEPTH_W;
  localparam int THREAD_SLOTS_M1 = cphss_pkg::THREAD_SLOTS - 1;

  cphss_pkg::state_t state_r, state_nxt;

  // request fields
  cphss_pkg::req_t    req_r;
  logic [31:0]        tag_r, faddr_r, raddr_r;
  logic [63:0]        ts_r;
  logic [ENT_W-1:0]   idx_r;

  cphss_pkg::status_t stat_r;
  logic [THR_W-1:0]   t_r;
  logic [DW-1:0]      lvl_r;
  logic               new_thr_r;
  logic [ENT_W-1:0]   e_r, c_r, probe_idx_r, clr_cnt_r;
  logic [ENT_W:0]     probe_cnt_r;
  logic [31:0]        ret_r;
  cphss_pkg::entry_t  res_r;

  // thread table
  logic [THREAD_SLOTS_M1:0] thr_valid_r;
  logic [31:0]   thr_tag_r [cphss_pkg::THREAD_SLOTS];
  logic [DW-1:0] thr_lvl_r [cphss_pkg::THREAD_SLOTS];

  // memories
  cphss_pkg::entry_t ent_mem [cphss_pkg::TABLE_SLOTS];
  cphss_pkg::frame_t stk_mem [cphss_pkg::THREAD_SLOTS * cphss_pkg::STACK_LEVELS];
  cphss_pkg::entry_t ent_q, ent_wdata, c_mod, e_mod;
  cphss_pkg::frame_t stk_q, stk_wdata;
  logic [ENT_W-1:0]       ent_raddr, ent_waddr;
  logic                   ent_we, stk_we;
  logic [THR_W+LVL_W-1:0] stk_raddr, stk_waddr;

  // output register
  logic               out_valid_r;
  cphss_pkg::status_t out_stat_r;
  logic [335:0]       out_data_r;
  logic [335:0]       out_data_nxt;
  logic               out_free;

  // thread probe
  logic             thr_hit, thr_free_ok;
  logic [THR_W-1:0] thr_hit_idx, thr_free_idx;
  logic [DW-1:0]    hit_lvl;
  logic             ent_match, probe_last;

  assign in_tready  = (state_r == cphss_pkg::S_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  always_comb begin
    logic             done;
    logic [THR_W-1:0] i;
    done         = 1'b0;
    thr_hit      = 1'b0;
    thr_free_ok  = 1'b0;
    thr_hit_idx  = '0;
    thr_free_idx = '0;
    for (int k = 0; k < cphss_pkg::THREAD_SLOTS; k++) begin
      i = THR_W'((tag_r % cphss_pkg::THREAD_SLOTS) + k);
      if (!done) begin
        if (!thr_valid_r[i]) begin
          thr_free_ok  = 1'b1;
          thr_free_idx = i;
          done         = 1'b1;
        end else if (thr_tag_r[i] == tag_r) begin
          thr_hit     = 1'b1;
          thr_hit_idx = i;
          done        = 1'b1;
        end
      end
    end
    hit_lvl = thr_lvl_r[thr_hit_idx];
  end

  assign ent_match  = !ent_q.valid || (ent_q.addr == faddr_r);
  assign probe_last = (probe_cnt_r == (ENT_W+1)'(cphss_pkg::TABLE_SLOTS - 1));

  // read-modify-write data
  always_comb begin
    c_mod = ent_q;
    e_mod = ent_q;
    if (req_r == cphss_pkg::REQ_ENTER) begin
      c_mod.away_cnt     = ent_q.away_cnt + 32'd1;
      c_mod.outside_time = ent_q.outside_time - ts_r;
      e_mod.valid        = 1'b1;
      e_mod.addr         = faddr_r;
      e_mod.enter_cnt    = ent_q.enter_cnt + 32'd1;
      e_mod.total_time   = ent_q.total_time - ts_r;
    end else begin
      c_mod.back_cnt     = ent_q.back_cnt + 32'd1;
      c_mod.outside_time = ent_q.outside_time + ts_r;
      e_mod.exit_cnt     = ent_q.exit_cnt + 32'd1;
      e_mod.total_time   = ent_q.total_time + ts_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cphss_pkg::S_CLEAR:
        if (clr_cnt_r == ENT_W'(cphss_pkg::TABLE_SLOTS - 1)) state_nxt = cphss_pkg::S_IDLE;
      cphss_pkg::S_IDLE:
        if (in_tvalid) state_nxt = cphss_pkg::S_DECODE;
      cphss_pkg::S_DECODE: begin
        case (req_r)
          cphss_pkg::REQ_ENTER:
            state_nxt = (thr_hit || thr_free_ok) ? cphss_pkg::S_PROBE : cphss_pkg::S_OUT;
          cphss_pkg::REQ_EXIT:
            state_nxt = (thr_hit && hit_lvl != '0) ? cphss_pkg::S_EXIT_STK
                                                    : cphss_pkg::S_OUT;
          cphss_pkg::REQ_READ: state_nxt = cphss_pkg::S_E_RD;
          default:             state_nxt = cphss_pkg::S_OUT;
        endcase
      end
      cphss_pkg::S_PROBE: state_nxt = cphss_pkg::S_PROBE_CHK;
      cphss_pkg::S_PROBE_CHK: begin
        if (ent_match) begin
          if (lvl_r[LVL_W])        state_nxt = cphss_pkg::S_OUT;
          else if (lvl_r != '0)    state_nxt = cphss_pkg::S_CALLER;
          else                     state_nxt = cphss_pkg::S_E_RD;
        end else begin
          state_nxt = probe_last ? cphss_pkg::S_OUT : cphss_pkg::S_PROBE;
        end
      end
      cphss_pkg::S_EXIT_STK:
        state_nxt = (lvl_r != '0) ? cphss_pkg::S_CALLER : cphss_pkg::S_E_RD;
      cphss_pkg::S_CALLER: state_nxt = cphss_pkg::S_C_MOD;
      cphss_pkg::S_C_MOD:  state_nxt = cphss_pkg::S_E_RD;
      cphss_pkg::S_E_RD:   state_nxt = cphss_pkg::S_E_MOD;
      cphss_pkg::S_E_MOD:  state_nxt = cphss_pkg::S_OUT;
      cphss_pkg::S_OUT:
        if (out_free) state_nxt = cphss_pkg::S_IDLE;
      default: state_nxt = cphss_pkg::S_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    logic [DW-1:0] lvl_dn;
    lvl_dn    = hit_lvl - DW'(1);
    ent_raddr = e_r;
    ent_waddr = e_r;
    ent_wdata = e_mod;
    ent_we    = 1'b0;
    stk_raddr = {t_r, LVL_W'(lvl_r - DW'(1))};
    stk_waddr = {t_r, lvl_r[LVL_W-1:0]};
    stk_wdata = '{slot: probe_idx_r, ret: raddr_r};
    stk_we    = 1'b0;
    case (state_r)
      cphss_pkg::S_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_cnt_r;
        ent_wdata = '0;
      end
      cphss_pkg::S_DECODE:  stk_raddr = {thr_hit_idx, lvl_dn[LVL_W-1:0]};
      cphss_pkg::S_PROBE:   ent_raddr = probe_idx_r;
      cphss_pkg::S_PROBE_CHK:
        stk_we = ent_match && !lvl_r[LVL_W];
      cphss_pkg::S_CALLER:  ent_raddr = stk_q.slot;
      cphss_pkg::S_C_MOD: begin
        ent_we    = 1'b1;
        ent_waddr = c_r;
        ent_wdata = c_mod;
      end
      cphss_pkg::S_E_MOD:
        ent_we = (req_r != cphss_pkg::REQ_READ);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_q <= ent_mem[ent_raddr];
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cphss_pkg::S_CLEAR;
      clr_cnt_r   <= '0;
      thr_valid_r <= '0;
      for (int k = 0; k < cphss_pkg::THREAD_SLOTS; k++) begin
        thr_tag_r[k] <= '0;
        thr_lvl_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        cphss_pkg::S_CLEAR: clr_cnt_r <= clr_cnt_r + ENT_W'(1);
        cphss_pkg::S_IDLE:
          if (in_tvalid) begin
            req_r   <= cphss_pkg::req_t'(in_tuser);
            tag_r   <= in_tdata[31:0];
            faddr_r <= in_tdata[63:32];
            raddr_r <= in_tdata[95:64];
            ts_r    <= in_tdata[159:96];
            idx_r   <= in_tdata[169:160];
            stat_r  <= cphss_pkg::ST_OK;
          end
        cphss_pkg::S_DECODE: begin
          probe_idx_r <= faddr_r[ENT_W-1:0];
          probe_cnt_r <= '0;
          e_r         <= idx_r;
          case (req_r)
            cphss_pkg::REQ_ENTER: begin
              t_r       <= thr_hit ? thr_hit_idx : thr_free_idx;
              lvl_r     <= thr_hit ? hit_lvl : '0;
              new_thr_r <= !thr_hit;
              if (!thr_hit && !thr_free_ok) stat_r <= cphss_pkg::ST_THREAD_FULL;
            end
            cphss_pkg::REQ_EXIT: begin
              if (!thr_hit || hit_lvl == '0) begin
                stat_r <= cphss_pkg::ST_UNDERFLOW;
              end else begin
                t_r                    <= thr_hit_idx;
                lvl_r                  <= hit_lvl - DW'(1);
                thr_lvl_r[thr_hit_idx] <= hit_lvl - DW'(1);
                // stack empties: free the thread slot
                if (hit_lvl == DW'(1)) begin
                  thr_valid_r[thr_hit_idx] <= 1'b0;
                  thr_tag_r[thr_hit_idx]   <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        cphss_pkg::S_PROBE_CHK: begin
          if (ent_match) begin
            if (lvl_r[LVL_W]) begin
              stat_r <= cphss_pkg::ST_OVERFLOW;
            end else begin
              e_r            <= probe_idx_r;
              thr_lvl_r[t_r] <= lvl_r + DW'(1);
              if (new_thr_r) begin
                thr_valid_r[t_r] <= 1'b1;
                thr_tag_r[t_r]   <= tag_r;
              end
            end
          end else begin
            probe_idx_r <= probe_idx_r + ENT_W'(1);
            probe_cnt_r <= probe_cnt_r + (ENT_W+1)'(1);
            if (probe_last) stat_r <= cphss_pkg::ST_FUNC_FULL;
          end
        end
        cphss_pkg::S_EXIT_STK: begin
          e_r   <= stk_q.slot;
          ret_r <= stk_q.ret;
        end
        cphss_pkg::S_CALLER: c_r <= stk_q.slot;
        cphss_pkg::S_E_MOD:
          res_r <= (req_r == cphss_pkg::REQ_READ) ? ent_q : e_mod;
        default: ;
      endcase
    end
  end

  // result payload; errors and the unused type carry only their status
  always_comb begin
    out_data_nxt = '0;
    if (stat_r == cphss_pkg::ST_OK && req_r != cphss_pkg::REQ_NONE) begin
      out_data_nxt[9:0]     = e_r;
      out_data_nxt[41:10]   = res_r.addr;
      out_data_nxt[73:42]   = res_r.enter_cnt;
      out_data_nxt[105:74]  = res_r.exit_cnt;
      out_data_nxt[137:106] = res_r.away_cnt;
      out_data_nxt[169:138] = res_r.back_cnt;
      out_data_nxt[233:170] = res_r.total_time;
      out_data_nxt[297:234] = res_r.outside_time;
      if (req_r == cphss_pkg::REQ_EXIT) out_data_nxt[329:298] = ret_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == cphss_pkg::S_OUT && out_free) ||
                     (out_valid_r && !out_tready);
      if (state_r == cphss_pkg::S_OUT && out_free) begin
        out_stat_r <= stat_r;
        out_data_r <= out_data_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/cphss_checker.sv =====
// ----------------------------------------------------------------------------
// cphss_checker
// Port-level checks for the call profiler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module cphss_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [335:0] out_tdata,
  input wire logic [2:0]   out_tuser
);

  // a result held back must stay
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= cphss_pkg::ST_UNDERFLOW)
    else $error("status code out of range");

  // an error result carries nothing but its status
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cphss_pkg::ST_OK |-> out_tdata == '0)
    else $error("error result with payload");

  // clearing pass runs after reset, so no result right after it
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result right after reset");

endmodule

bind call_profiler_hash_shadow_stack_top cphss_checker u_cphss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// ===== tb/call_profiler_hash_shadow_stack_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// call_profiler_hash_shadow_stack_top_tb
// Streams enter, exit and read requests into the call profiler. A local copy
// of the thread table, function table and shadow stacks predicts each
// response, and the responses are checked field by field in order. The
// stimulus covers nested call chains on a few threads, a full thread table,
// a stack overflow and random noise requests.
// ----------------------------------------------------------------------------
module call_profiler_hash_shadow_stack_top_tb;

  localparam int LIMIT = 3000000;

  typedef struct {
    cphss_pkg::req_t kind;
    logic [31:0] tag;
    logic [31:0] faddr;
    logic [31:0] raddr;
    logic [63:0] ts;
    logic [9:0]  idx;
  } event_t;

  typedef struct {
    cphss_pkg::status_t st;
    logic [9:0]  slot;
    logic [31:0] addr;
    logic [31:0] n_enter;
    logic [31:0] n_exit;
    logic [31:0] n_away;
    logic [31:0] n_back;
    logic [63:0] t_total;
    logic [63:0] t_outside;
    logic [31:0] ret;
  } stats_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [175:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [335:0] out_tdata;
  logic [2:0]   out_tuser;

  call_profiler_hash_shadow_stack_top DUT (.*);

  always #1 clk = ~clk;

  // profiler state as seen from outside
  bit          ent_used [cphss_pkg::TABLE_SLOTS];
  logic [31:0] ent_addr [cphss_pkg::TABLE_SLOTS];
  logic [31:0] cnt_enter [cphss_pkg::TABLE_SLOTS];
  logic [31:0] cnt_exit [cphss_pkg::TABLE_SLOTS];
  logic [31:0] cnt_away [cphss_pkg::TABLE_SLOTS];
  logic [31:0] cnt_back [cphss_pkg::TABLE_SLOTS];
  logic [63:0] tm_total [cphss_pkg::TABLE_SLOTS];
  logic [63:0] tm_outside [cphss_pkg::TABLE_SLOTS];
  bit          thr_used [cphss_pkg::THREAD_SLOTS];
  logic [31:0] thr_tag [cphss_pkg::THREAD_SLOTS];
  int          thr_depth [cphss_pkg::THREAD_SLOTS];
  logic [31:0] stk_ret [cphss_pkg::THREAD_SLOTS][cphss_pkg::STACK_LEVELS];
  logic [9:0]  stk_slot [cphss_pkg::THREAD_SLOTS][cphss_pkg::STACK_LEVELS];

  event_t pending_events[$];
  stats_t expected_stats[$];
  event_t cur_ev;
  int     send_idle = 32;
  int     recv_idle = 85;
  bit     hold_send = 1'b0;
  int     mismatches = 0;
  int     cycles = 0;

  logic [31:0] tag_pool [6];
  logic [31:0] func_pool [40];
  int          gen_depth [6];

  function automatic stats_t entry_view(int e);
    stats_t r;
    r = '{st: cphss_pkg::ST_OK, default: '0};
    r.slot = e[9:0];
    r.addr = ent_addr[e];
    r.n_enter = cnt_enter[e];
    r.n_exit = cnt_exit[e];
    r.n_away = cnt_away[e];
    r.n_back = cnt_back[e];
    r.t_total = tm_total[e];
    r.t_outside = tm_outside[e];
    return r;
  endfunction

  function automatic stats_t profile_event(event_t ev);
    stats_t r;
    int t, fr, e, i, lvl, c;
    r = '{st: cphss_pkg::ST_OK, default: '0};
    t = -1;
    fr = -1;
    e = -1;
    if (ev.kind == cphss_pkg::REQ_ENTER || ev.kind == cphss_pkg::REQ_EXIT) begin
      for (int k = 0; k < cphss_pkg::THREAD_SLOTS; k++) begin
        i = (int'(ev.tag[2:0]) + k) % cphss_pkg::THREAD_SLOTS;
        if (!thr_used[i]) begin
          fr = i;
          break;
        end
        if (thr_tag[i] == ev.tag) begin
          t = i;
          break;
        end
      end
    end
    case (ev.kind)
      cphss_pkg::REQ_ENTER: begin
        if (t < 0 && fr < 0) begin
          r.st = cphss_pkg::ST_THREAD_FULL;
          return r;
        end
        for (int k = 0; k < cphss_pkg::TABLE_SLOTS; k++) begin
          i = (int'(ev.faddr[9:0]) + k) % cphss_pkg::TABLE_SLOTS;
          if (!ent_used[i] || ent_addr[i] == ev.faddr) begin
            e = i;
            break;
          end
        end
        if (e < 0) begin
          r.st = cphss_pkg::ST_FUNC_FULL;
          return r;
        end
        lvl = (t >= 0) ? thr_depth[t] : 0;
        if (lvl >= cphss_pkg::STACK_LEVELS) begin
          r.st = cphss_pkg::ST_OVERFLOW;
          return r;
        end
        if (t < 0) begin
          t = fr;
          thr_used[t] = 1'b1;
          thr_tag[t] = ev.tag;
          thr_depth[t] = 0;
        end
        if (!ent_used[e]) begin
          ent_used[e] = 1'b1;
          ent_addr[e] = ev.faddr;
        end
        stk_slot[t][lvl] = e[9:0];
        stk_ret[t][lvl] = ev.raddr;
        thr_depth[t] = lvl + 1;
        if (lvl > 0) begin
          c = int'(stk_slot[t][lvl-1]);
          cnt_away[c] += 32'd1;
          tm_outside[c] -= ev.ts;
        end
        cnt_enter[e] += 32'd1;
        tm_total[e] -= ev.ts;
        r = entry_view(e);
      end
      cphss_pkg::REQ_EXIT: begin
        if (t < 0 || thr_depth[t] == 0) begin
          r.st = cphss_pkg::ST_UNDERFLOW;
          return r;
        end
        lvl = thr_depth[t] - 1;
        thr_depth[t] = lvl;
        e = int'(stk_slot[t][lvl]);
        cnt_exit[e] += 32'd1;
        tm_total[e] += ev.ts;
        if (lvl > 0) begin
          c = int'(stk_slot[t][lvl-1]);
          cnt_back[c] += 32'd1;
          tm_outside[c] += ev.ts;
        end else begin
          thr_used[t] = 1'b0;
          thr_tag[t] = '0;
        end
        r = entry_view(e);
        r.ret = stk_ret[t][lvl];
      end
      cphss_pkg::REQ_READ: r = entry_view(int'(ev.idx));
      default: ;
    endcase
    return r;
  endfunction

  // drive requests from the pending queue, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_stats.push_back(profile_event(cur_ev));
      if (!in_tvalid || in_tready) begin
        if (pending_events.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          cur_ev = pending_events.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {6'd0, cur_ev.idx, cur_ev.ts, cur_ev.raddr, cur_ev.faddr, cur_ev.tag};
          in_tuser <= cur_ev.kind;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic bit field_ok(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v === got_v) return 1'b1;
    if (mismatches < 10)
      $display("mismatch %s: expected %h got %h", name, exp_v, got_v);
    mismatches++;
    return 1'b0;
  endfunction

  // check responses against the oldest prediction
  always @(posedge clk) begin
    stats_t x;
    bit ok;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        if (expected_stats.size() == 0) begin
          if (mismatches < 10) $display("unexpected response %h", out_tdata);
          mismatches++;
        end else begin
          x = expected_stats.pop_front();
          ok = field_ok("status", 64'(x.st), 64'(out_tuser));
          ok = field_ok("slot_index", 64'(x.slot), 64'(out_tdata[9:0]));
          ok = field_ok("entry_addr", 64'(x.addr), 64'(out_tdata[41:10]));
          ok = field_ok("enter_count", 64'(x.n_enter), 64'(out_tdata[73:42]));
          ok = field_ok("exit_count", 64'(x.n_exit), 64'(out_tdata[105:74]));
          ok = field_ok("away_count", 64'(x.n_away), 64'(out_tdata[137:106]));
          ok = field_ok("back_count", 64'(x.n_back), 64'(out_tdata[169:138]));
          ok = field_ok("total_time_acc", x.t_total, out_tdata[233:170]);
          ok = field_ok("outside_time_acc", x.t_outside, out_tdata[297:234]);
          ok = field_ok("popped_return", 64'(x.ret), 64'(out_tdata[329:298]));
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push_ev(cphss_pkg::req_t kind, logic [31:0] tag, logic [31:0] faddr,
                         logic [63:0] ts, logic [9:0] idx);
    event_t ev;
    ev.kind = kind;
    ev.tag = tag;
    ev.faddr = faddr;
    ev.raddr = $urandom();
    ev.ts = ts;
    ev.idx = idx;
    pending_events.push_back(ev);
  endtask

  task automatic push_random();
    int r, p;
    r = $urandom_range(99);
    p = $urandom_range(5);
    if (r < 8) begin
      push_ev(cphss_pkg::REQ_READ, $urandom(), $urandom(), rand64(), 10'($urandom()));
    end else if (r < 10) begin
      push_ev(cphss_pkg::REQ_NONE, $urandom(), $urandom(), rand64(), 10'($urandom()));
    end else if (r < 13) begin
      push_ev(cphss_pkg::REQ_EXIT, $urandom(), $urandom(), rand64(), 10'($urandom()));
    end else if (r < 15) begin
      // one-shot call from an unknown thread into a random address
      push_ev(cphss_pkg::REQ_ENTER, 32'hC0DE0000 | 32'($urandom_range(255)), $urandom(),
              rand64(), 10'($urandom()));
      push_ev(cphss_pkg::REQ_EXIT, pending_events[$].tag, $urandom(), rand64(),
              10'($urandom()));
    end else if (gen_depth[p] == 0 || (gen_depth[p] < 12 && $urandom_range(99) < 55)) begin
      push_ev(cphss_pkg::REQ_ENTER, tag_pool[p], func_pool[$urandom_range(39)], rand64(),
              10'($urandom()));
      gen_depth[p]++;
    end else begin
      push_ev(cphss_pkg::REQ_EXIT, tag_pool[p], $urandom(), rand64(), 10'($urandom()));
      gen_depth[p]--;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_events.size() > 0 || in_tvalid || expected_stats.size() > 0);
  endtask

  initial begin
    logic [31:0] deep_tag;
    foreach (ent_addr[i]) begin
      ent_addr[i] = '0;
      cnt_enter[i] = '0;
      cnt_exit[i] = '0;
      cnt_away[i] = '0;
      cnt_back[i] = '0;
      tm_total[i] = '0;
      tm_outside[i] = '0;
    end
    foreach (thr_tag[i]) thr_tag[i] = '0;
    tag_pool = '{32'h0, 32'hFFFFFFFF, 32'h8, 32'h10, 32'h1234_5671, 32'h9};
    foreach (func_pool[i]) func_pool[i] = (i < 8) ? 32'(i * 1024) : $urandom();
    func_pool[38] = 32'h0;
    func_pool[39] = 32'hFFFFFFFF;
    foreach (gen_depth[i]) gen_depth[i] = 0;

    // directed: empty reads, unused type, zero and all-ones fields, underflow
    push_ev(cphss_pkg::REQ_READ, '0, '0, '0, 10'd0);
    push_ev(cphss_pkg::REQ_READ, '1, '1, '1, 10'h3FF);
    push_ev(cphss_pkg::REQ_NONE, '1, '1, '1, '1);
    push_ev(cphss_pkg::REQ_EXIT, '0, '0, '0, '0);
    push_ev(cphss_pkg::REQ_ENTER, '0, '0, 64'd5, '0);
    push_ev(cphss_pkg::REQ_ENTER, '0, '1, '1, '1);
    push_ev(cphss_pkg::REQ_ENTER, '0, 32'h400, 64'd100, '0);
    push_ev(cphss_pkg::REQ_EXIT, '0, '0, 64'd200, '0);
    push_ev(cphss_pkg::REQ_EXIT, '0, '0, '0, '0);
    push_ev(cphss_pkg::REQ_EXIT, '0, '0, '1, '0);
    push_ev(cphss_pkg::REQ_EXIT, '0, '0, 64'd7, '0);
    push_ev(cphss_pkg::REQ_READ, '0, '0, '0, 10'h3FF);
    push_ev(cphss_pkg::REQ_READ, '0, '0, '0, 10'd0);
    // fill the thread table, then one more thread
    for (int i = 1; i <= 9; i++) push_ev(cphss_pkg::REQ_ENTER, 32'(i), 32'h77, rand64(), '0);
    for (int i = 1; i <= 8; i++) push_ev(cphss_pkg::REQ_EXIT, 32'(i), '0, rand64(), '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 95; i++) push_random();
    wait_idle();
    send_idle = 85;
    recv_idle = 32;
    for (int i = 0; i < 95; i++) push_random();
    // hold off mid-stream until every result has come back
    while (pending_events.size() > 45) @(negedge clk);
    hold_send = 1'b1;
    do @(negedge clk);
    while (in_tvalid || expected_stats.size() > 0);
    hold_send = 1'b0;
    wait_idle();
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 95; i++) push_random();
    wait_idle();

    // unwind every live thread so the deep test has room
    for (int s = 0; s < cphss_pkg::THREAD_SLOTS; s++)
      if (thr_used[s])
        for (int d = 0; d < thr_depth[s]; d++)
          push_ev(cphss_pkg::REQ_EXIT, thr_tag[s], '0, rand64(), '0);
    wait_idle();

    // overflow the shadow stack of one thread
    deep_tag = $urandom();
    for (int i = 0; i <= cphss_pkg::STACK_LEVELS; i++)
      push_ev(cphss_pkg::REQ_ENTER, deep_tag, func_pool[$urandom_range(39)], rand64(), '0);
    wait_idle();

    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_stats.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
